// File: sv/gpcd_pkg.sv
// Shared types and constants for the grouped packed-code dequantizer.
// No dependencies; imported by the unpacker, MAC and core modules.
`default_nettype none

package gpcd_pkg;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    localparam logic [CFG_AW-1:0] CFG_CODE_WIDTH    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_VECTOR_LENGTH = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_GROUP_LENGTH  = 2'd2;

    localparam logic [3:0]  CODE_WIDTH_RST    = 4'd4;
    localparam logic [12:0] VECTOR_LENGTH_RST = 13'd128;
    localparam logic [12:0] GROUP_LENGTH_RST  = 13'd32;

    // token length limit: the smaller of the vector capacity and 4096
    localparam int MAX_VECTOR = 4096;
    localparam int VEC_LIMIT  = (MAX_VECTOR < 4096) ? MAX_VECTOR : 4096;
    localparam int GRP_LIMIT  = 4096;

    localparam int MAX_GROUPS_DEF = 256;

    // input word kinds
    localparam logic ACT_TABLE = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // table entry: scale in the low half, zero point in the high half
    localparam int ENTRY_W = 64;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// File: sv/gpcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gpcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/gpcd_mac.sv
// Shared multiply-add-saturate unit: code * scale, then + zero point, clipped to 32 bits.
// Depends on gpcd_pkg (control struct).
`default_nettype none

module gpcd_mac (
    input  wire logic                 i_clk,
    input  wire gpcd_pkg::t_mac_ctrl  i_ctrl,
    input  wire logic [7:0]           i_code,
    input  wire logic [63:0]          i_entry,
    output logic      [31:0]          o_value,
    output logic                      o_sat
);
    import gpcd_pkg::*;

    localparam logic signed [41:0] SUM_MAX = 42'sh0007FFFFFFF;
    localparam logic signed [41:0] SUM_MIN = -42'sh00080000000;

    logic signed [40:0] r_prod;
    logic signed [41:0] w_sum;
    logic               w_hi;
    logic               w_lo;

    // 9x32 signed product, registered before the add
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= $signed({1'b0, i_code}) * $signed(i_entry[31:0]);
        end
    end

    always_comb begin
        w_sum = $signed({r_prod[40], r_prod})
              + $signed({{10{i_entry[63]}}, i_entry[63:32]});
        w_hi  = (w_sum > SUM_MAX);
        w_lo  = (w_sum < SUM_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.add_en) begin
            o_sat <= w_hi | w_lo;
            if (w_hi) begin
                o_value <= 32'h7FFF_FFFF;
            end else if (w_lo) begin
                o_value <= 32'h8000_0000;
            end else begin
                o_value <= w_sum[31:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/gpcd_unpack.sv
// Bit unpacker and sequencer: config registers, bit buffer, token/group counters,
// and the per-code step control for the table read and the shared MAC.
// Depends on gpcd_pkg.
`default_nettype none

module gpcd_unpack #(
    parameter int MAX_GROUPS = gpcd_pkg::MAX_GROUPS_DEF
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_cfg_we,
    input  wire logic [gpcd_pkg::CFG_AW-1:0]                     i_cfg_addr,
    input  wire logic [gpcd_pkg::CFG_DW-1:0]                     i_cfg_data,
    input  wire logic                                            i_valid,
    output logic                                                 o_ready,
    input  wire logic                                            i_action,
    input  wire logic [7:0]                                      i_slot,
    input  wire logic [7:0]                                      i_byte,
    output logic                                                 o_we,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] o_waddr,
    output logic                                                 o_re,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] o_raddr,
    output gpcd_pkg::t_mac_ctrl                                  o_ctrl,
    output logic [7:0]                                           o_code,
    output logic                                                 o_valid,
    input  wire logic                                            i_ready,
    output logic [11:0]                                          o_coord,
    output logic                                                 o_last
);
    import gpcd_pkg::*;

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [3:0]  r_cw;
    logic [12:0] r_vl;
    logic [12:0] r_gl;

    logic [2:0]    r_state, n_state;
    logic [14:0]   r_buf,   n_buf;
    logic [3:0]    r_cnt,   n_cnt;
    logic [11:0]   r_pos,   n_pos;
    logic [11:0]   r_gpos,  n_gpos;
    logic [GW-1:0] r_grp,   n_grp;
    logic [7:0]    r_code,  n_code;
    logic          r_last,  n_last;

    logic [3:0]  w_cw;
    logic [12:0] w_vl;
    logic [12:0] w_gl;
    logic [7:0]  w_mask;
    logic [12:0] w_slot;
    logic [12:0] w_gpos_inc;
    logic        w_cfg_hit;

    // effective register values: zero acts as one, large values clamp
    always_comb begin
        if (r_cw == 4'd0)      w_cw = 4'd1;
        else if (r_cw > 4'd8)  w_cw = 4'd8;
        else                   w_cw = r_cw;

        if (r_vl == 13'd0)                 w_vl = 13'd1;
        else if (r_vl > 13'(VEC_LIMIT))    w_vl = 13'(VEC_LIMIT);
        else                               w_vl = r_vl;

        if (r_gl == 13'd0)                 w_gl = 13'd1;
        else if (r_gl > 13'(GRP_LIMIT))    w_gl = 13'(GRP_LIMIT);
        else                               w_gl = r_gl;
    end

    assign w_mask     = 8'hFF >> (4'd8 - w_cw);
    assign w_slot     = {5'd0, i_slot};
    assign w_gpos_inc = {1'b0, r_gpos} + 13'd1;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_addr == CFG_CODE_WIDTH
                                  || i_cfg_addr == CFG_VECTOR_LENGTH
                                  || i_cfg_addr == CFG_GROUP_LENGTH);

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_we    = o_ready && i_valid && (i_action == ACT_TABLE)
                  && (w_slot < 13'(MAX_GROUPS));
    assign o_waddr = w_slot[GW-1:0];
    assign o_raddr = r_grp;
    assign o_code  = r_code;
    assign o_coord = r_pos;
    assign o_last  = r_last;

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_gpos  = r_gpos;
        n_grp   = r_grp;
        n_code  = r_code;
        n_last  = r_last;
        o_re    = 1'b0;
        o_ctrl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_action == ACT_BYTE) begin
                    n_buf   = r_buf | ({7'd0, i_byte} << r_cnt[2:0]);
                    n_cnt   = r_cnt + 4'd8;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_cnt >= w_cw) begin
                    o_re    = 1'b1;
                    n_code  = r_buf[7:0] & w_mask;
                    n_buf   = r_buf >> w_cw;
                    n_cnt   = r_cnt - w_cw;
                    n_last  = ({1'b0, r_pos} + 13'd1) >= w_vl;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_ctrl.mul_en = 1'b1;
                n_state       = ST_ADD;
            end
            ST_ADD: begin
                o_ctrl.add_en = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    if (r_last) begin
                        // token done: padding bits are dropped
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_gpos  = '0;
                        n_grp   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = r_pos + 12'd1;
                        n_state = ST_CHECK;
                        if (w_gpos_inc >= w_gl) begin
                            n_gpos = '0;
                            if (r_grp < GW'(MAX_GROUPS - 1)) begin
                                n_grp = r_grp + GW'(1);
                            end
                        end else begin
                            n_gpos = w_gpos_inc[11:0];
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // any register write restarts the token
        if (w_cfg_hit) begin
            n_buf  = '0;
            n_cnt  = '0;
            n_pos  = '0;
            n_gpos = '0;
            n_grp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw    <= CODE_WIDTH_RST;
            r_vl    <= VECTOR_LENGTH_RST;
            r_gl    <= GROUP_LENGTH_RST;
            r_state <= ST_IDLE;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_gpos  <= '0;
            r_grp   <= '0;
            r_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CODE_WIDTH:    r_cw <= i_cfg_data[3:0];
                    CFG_VECTOR_LENGTH: r_vl <= i_cfg_data;
                    CFG_GROUP_LENGTH:  r_gl <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= n_state;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_gpos  <= n_gpos;
            r_grp   <= n_grp;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

endmodule

`default_nettype wire

// File: sv/grouped_packed_code_dequantizer_core.sv
// A table word is written to the group table as it is accepted. A data word is unpacked
// code by code; each code steps through table read, multiply, add/saturate and output
// on the one shared multiplier, and the next word is accepted only once all of the
// word's codes are done, output stall time included.
// Synchronous active-low reset restores register defaults, clears bit buffer and
// counters; the group table is not cleared. Depends on gpcd_pkg, unpack, mac and ram.
`default_nettype none

module grouped_packed_code_dequantizer_core #(
    parameter int MAX_GROUPS = gpcd_pkg::MAX_GROUPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gpcd_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [gpcd_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // group_slot[7:0], scale[39:8], zero_point[71:40], data_byte[79:72]
    input  wire logic [79:0]                   s_axis_tdata,
    // action[0]
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // value[31:0], coordinate[43:32], zero fill [47:44]
    output logic [47:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    // saturated[0]
    output logic                               m_axis_tuser
);
    import gpcd_pkg::*;

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic              w_we;
    logic [GW-1:0]     w_waddr;
    logic              w_re;
    logic [GW-1:0]     w_raddr;
    logic [ENTRY_W-1:0] w_entry;
    t_mac_ctrl         w_ctrl;
    logic [7:0]        w_code;
    logic [11:0]       w_coord;
    logic [31:0]       w_value;

    gpcd_unpack #(
        .MAX_GROUPS(MAX_GROUPS)
    ) u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_slot     (s_axis_tdata[7:0]),
        .i_byte     (s_axis_tdata[79:72]),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .o_ctrl     (w_ctrl),
        .o_code     (w_code),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_coord    (w_coord),
        .o_last     (m_axis_tlast)
    );

    gpcd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_GROUPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[71:8]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_entry)
    );

    gpcd_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_code  (w_code),
        .i_entry (w_entry),
        .o_value (w_value),
        .o_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, w_coord, w_value};

endmodule

`default_nettype wire

// File: sv/gpcd_checker.sv
// Port-level checker for the dequantizer core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module gpcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic        m_axis_tlast
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // input is never taken while a result is waiting
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // after a table write the input is ready again in the next cycle, with no result
    a_table_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser
        |=> s_axis_tready && !m_axis_tvalid)
        else $error("table write did not complete in one cycle");

    // a data word holds off input while it is unpacked
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("data word did not start unpacking");

    // end of token returns to idle
    a_token_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> s_axis_tready && !m_axis_tvalid)
        else $error("no return to idle after last word of token");

endmodule

bind grouped_packed_code_dequantizer_core gpcd_checker u_gpcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
